// ===== hdl/cfr_pkg.sv =====
// Shared types and constants of the controller frame receiver.
package cfr_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADSUM  = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_TOOLONG = 2'd3;

    // Input item kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Held controller data
    localparam int HELD_DEPTH = 6;
    localparam int HELD_IDX_W = $clog2(HELD_DEPTH);
    localparam int HELD_CNT_W = $clog2(HELD_DEPTH + 1);

    // Event queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Register map
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    typedef logic [7:0] byte_t;

    // One classified event: status plus the bytes to commit on success
    typedef struct packed {
        logic [1:0]                  status;
        logic [HELD_CNT_W-1:0]       commit_cnt;
        byte_t [HELD_DEPTH-1:0]      stage;
    } cfr_event_t;

endpackage

// ===== hdl/cfr_front.sv =====
// Front part: parses bytes and ticks into frame events.
module cfr_front #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [15:0]         timeout_ticks,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  logic [7:0]          s_rx_byte,
    input  logic                ev_ready,
    output logic                ev_valid,
    output cfr_pkg::cfr_event_t ev
);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_CSUM = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  xor_reg, xor_next;
    logic [15:0] elapsed_reg, elapsed_next;
    cfr_pkg::byte_t stage_reg  [cfr_pkg::HELD_DEPTH];
    cfr_pkg::byte_t stage_next [cfr_pkg::HELD_DEPTH];

    logic        accept;
    logic [15:0] elapsed_inc;
    logic [7:0]  count_inc;
    logic        sum_ok;

    assign s_ready     = ev_ready;
    assign accept      = s_valid && s_ready;
    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign count_inc   = count_reg + 8'd1;
    assign sum_ok      = (s_rx_byte == xor_reg) || (xor_reg == 8'hFF && s_rx_byte == 8'hFE);

    always_comb begin
        phase_next   = phase_reg;
        len_next     = len_reg;
        count_next   = count_reg;
        xor_next     = xor_reg;
        elapsed_next = elapsed_reg;
        stage_next   = stage_reg;
        ev_valid     = 1'b0;
        ev.status    = cfr_pkg::ST_OK;
        ev.commit_cnt = '0;
        for (int i = 0; i < cfr_pkg::HELD_DEPTH; i++) begin
            ev.stage[i] = stage_reg[i];
        end
        if (accept) begin
            if (s_req_type == cfr_pkg::REQ_TICK) begin
                if (phase_reg != PH_HUNT) begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc > timeout_ticks) begin
                        phase_next   = PH_HUNT;
                        count_next   = '0;
                        xor_next     = '0;
                        elapsed_next = '0;
                        ev_valid     = 1'b1;
                        ev.status    = cfr_pkg::ST_TIMEOUT;
                    end
                end
            end else begin
                unique case (phase_reg)
                    PH_HUNT: begin
                        if (s_rx_byte == 8'hFF) begin
                            phase_next   = PH_LEN;
                            elapsed_next = '0;
                        end
                    end
                    PH_LEN: begin
                        len_next   = s_rx_byte;
                        count_next = '0;
                        xor_next   = '0;
                        if (s_rx_byte > 8'(MAX_PAYLOAD)) begin
                            phase_next   = PH_HUNT;
                            elapsed_next = '0;
                            ev_valid     = 1'b1;
                            ev.status    = cfr_pkg::ST_TOOLONG;
                        end else begin
                            phase_next = (s_rx_byte == 8'd0) ? PH_CSUM : PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        if (count_reg < 8'(cfr_pkg::HELD_DEPTH)) begin
                            stage_next[count_reg[cfr_pkg::HELD_IDX_W-1:0]] = s_rx_byte;
                        end
                        xor_next   = xor_reg ^ s_rx_byte;
                        count_next = count_inc;
                        if (count_inc >= len_reg) begin
                            phase_next = PH_CSUM;
                        end
                    end
                    PH_CSUM: begin
                        phase_next   = PH_HUNT;
                        count_next   = '0;
                        xor_next     = '0;
                        elapsed_next = '0;
                        ev_valid     = 1'b1;
                        if (sum_ok) begin
                            ev.status = cfr_pkg::ST_OK;
                            ev.commit_cnt = (len_reg > 8'(cfr_pkg::HELD_DEPTH)) ?
                                cfr_pkg::HELD_CNT_W'(cfr_pkg::HELD_DEPTH) :
                                len_reg[cfr_pkg::HELD_CNT_W-1:0];
                        end else begin
                            ev.status = cfr_pkg::ST_BADSUM;
                        end
                    end
                    default: begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            len_reg     <= '0;
            count_reg   <= '0;
            xor_reg     <= '0;
            elapsed_reg <= '0;
        end else begin
            phase_reg   <= phase_next;
            len_reg     <= len_next;
            count_reg   <= count_next;
            xor_reg     <= xor_next;
            elapsed_reg <= elapsed_next;
        end
    end

    always_ff @(posedge aclk) begin
        stage_reg <= stage_next;
    end

endmodule

// ===== hdl/cfr_queue.sv =====
// Short event queue between the front and back parts.
module cfr_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  cfr_pkg::cfr_event_t in_ev,
    output logic                out_valid,
    input  logic                out_ready,
    output cfr_pkg::cfr_event_t out_ev
);

    cfr_pkg::cfr_event_t mem_reg [cfr_pkg::Q_DEPTH];
    logic [cfr_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [cfr_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [cfr_pkg::Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic push, pop;

    assign in_ready  = (cnt_reg != cfr_pkg::Q_CNT_W'(cfr_pkg::Q_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_ev    = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == cfr_pkg::Q_PTR_W'(cfr_pkg::Q_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == cfr_pkg::Q_PTR_W'(cfr_pkg::Q_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_ev;
        end
    end

endmodule

// ===== hdl/cfr_back.sv =====
// Back part: commits frames to the held data and registers decoded results.
module cfr_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                ev_valid,
    output logic                ev_ready,
    input  cfr_pkg::cfr_event_t ev,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic signed [8:0]   m_stick_0,
    output logic signed [8:0]   m_stick_1,
    output logic signed [8:0]   m_stick_2,
    output logic signed [8:0]   m_stick_3,
    output logic [3:0]          m_switch_main,
    output logic [1:0]          m_switch_1,
    output logic [1:0]          m_switch_2,
    output logic [1:0]          m_switch_3,
    output logic [1:0]          m_switch_4
);

    cfr_pkg::byte_t held_reg  [cfr_pkg::HELD_DEPTH];
    cfr_pkg::byte_t held_next [cfr_pkg::HELD_DEPTH];
    logic signed [8:0] stick_next [4];
    logic signed [8:0] stick_reg  [4];
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  status_reg;
    logic [7:0]  sw_byte_reg;
    logic [3:0]  main_reg;
    logic        pop;

    assign ev_ready = !m_valid_reg || m_ready;
    assign pop      = ev_valid && ev_ready;

    always_comb begin
        for (int i = 0; i < cfr_pkg::HELD_DEPTH; i++) begin
            held_next[i] = (cfr_pkg::HELD_CNT_W'(i) < ev.commit_cnt) ? ev.stage[i] : held_reg[i];
        end
        for (int k = 0; k < 4; k++) begin
            stick_next[k] = held_next[0][k] ? -$signed({1'b0, held_next[k + 1]}) :
                                               $signed({1'b0, held_next[k + 1]});
        end
        m_valid_next = pop ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            for (int i = 0; i < cfr_pkg::HELD_DEPTH; i++) begin
                held_reg[i] <= '0;
            end
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                held_reg <= held_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            status_reg  <= ev.status;
            stick_reg   <= stick_next;
            main_reg    <= held_next[0][7:4];
            sw_byte_reg <= held_next[cfr_pkg::HELD_DEPTH - 1];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_stick_0     = stick_reg[0];
    assign m_stick_1     = stick_reg[1];
    assign m_stick_2     = stick_reg[2];
    assign m_stick_3     = stick_reg[3];
    assign m_switch_main = main_reg;
    assign m_switch_1    = sw_byte_reg[1:0];
    assign m_switch_2    = sw_byte_reg[3:2];
    assign m_switch_3    = sw_byte_reg[5:4];
    assign m_switch_4    = sw_byte_reg[7:6];

endmodule

// ===== hdl/controller_frame_receiver_top.sv =====
// Top level of the controller frame receiver.
//
//  channel  | ports                        | carries
//  ---------+------------------------------+----------------------------------------
//  input    | s_valid/s_ready, s_*         | one received byte or one time tick
//  result   | m_valid/m_ready, m_*         | status and decoded controller values
//  config   | psel/penable/pwrite/paddr    | timeout_ticks at byte address 0
//
//  One input transfer is taken per cycle while the queue has room; the byte parser
//  updates its state in the accepting cycle, so the sustained rate is one item per clock.
//  A result passes from the transfer that caused it into the event queue, then through
//  the commit and decode stage into the output register.
//  aresetn is synchronous and active low; it empties the queue and output register,
//  returns the parser to header hunting, zeroes the held data and loads timeout 100.
//  A stalled result side fills the two-entry event queue; only then does s_ready drop.
module controller_frame_receiver_top #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [7:0]         s_rx_byte,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [8:0]  m_stick_0,
    output logic signed [8:0]  m_stick_1,
    output logic signed [8:0]  m_stick_2,
    output logic signed [8:0]  m_stick_3,
    output logic [3:0]         m_switch_main,
    output logic [1:0]         m_switch_1,
    output logic [1:0]         m_switch_2,
    output logic [1:0]         m_switch_3,
    output logic [1:0]         m_switch_4
);

    logic [15:0] timeout_reg, timeout_next;
    logic        cfg_write;

    // front -> queue
    logic                fe_valid;
    logic                fe_ready;
    cfr_pkg::cfr_event_t fe_ev;

    // queue -> back
    logic                q_valid;
    logic                q_ready;
    cfr_pkg::cfr_event_t q_ev;

    // Configuration: register index is paddr[2], writes beyond the map drop
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == cfr_pkg::REG_TIMEOUT) ? {16'd0, timeout_reg} : 32'd0;

    always_comb begin
        timeout_next = timeout_reg;
        if (cfg_write && paddr[2] == cfr_pkg::REG_TIMEOUT) begin
            timeout_next = pwdata[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= cfr_pkg::TIMEOUT_RESET;
        end else begin
            timeout_reg <= timeout_next;
        end
    end

    // Parse and classify each transfer
    cfr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .timeout_ticks (timeout_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_rx_byte     (s_rx_byte),
        .ev_ready      (fe_ready),
        .ev_valid      (fe_valid),
        .ev            (fe_ev)
    );

    // Decouple parser from result stalls
    cfr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_ev     (fe_ev),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_ev    (q_ev)
    );

    // Commit accepted frames and decode the held data
    cfr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ev_valid      (q_valid),
        .ev_ready      (q_ready),
        .ev            (q_ev),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_stick_0     (m_stick_0),
        .m_stick_1     (m_stick_1),
        .m_stick_2     (m_stick_2),
        .m_stick_3     (m_stick_3),
        .m_switch_main (m_switch_main),
        .m_switch_1    (m_switch_1),
        .m_switch_2    (m_switch_2),
        .m_switch_3    (m_switch_3),
        .m_switch_4    (m_switch_4)
    );

`ifndef NO_ASSERTIONS
    // An event is only raised on a transfer the queue has room for
    assert property (@(posedge aclk) disable iff (!aresetn)
        fe_valid |-> (fe_ready && s_valid && s_ready))
        else $error("front raised an event without an accepted transfer");

    // Failed, timed-out and oversize frames commit nothing
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ev.status != cfr_pkg::ST_OK) |-> (q_ev.commit_cnt == '0))
        else $error("non-ok event carries bytes to commit");

    // Never commit more than the held data holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> (q_ev.commit_cnt <= cfr_pkg::HELD_CNT_W'(cfr_pkg::HELD_DEPTH)))
        else $error("commit count beyond held data depth");

    // A new result appears only after an event was taken from the queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(q_valid && q_ready))
        else $error("result raised without a queued event");
`endif

endmodule

// ===== verif/cfr_frame_monitor.sv =====
`timescale 1ns / 1ps
// Frame receiver monitor: predicts every result from the input transfers and compares it.
module cfr_frame_monitor #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic [31:0]       prdata,
    input  logic              pready,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic              s_req_type,
    input  logic [7:0]        s_rx_byte,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [1:0]        m_status,
    input  logic signed [8:0] m_stick_0,
    input  logic signed [8:0] m_stick_1,
    input  logic signed [8:0] m_stick_2,
    input  logic signed [8:0] m_stick_3,
    input  logic [3:0]        m_switch_main,
    input  logic [1:0]        m_switch_1,
    input  logic [1:0]        m_switch_2,
    input  logic [1:0]        m_switch_3,
    input  logic [1:0]        m_switch_4,
    output int                fail_count,
    output int                pending,
    output int                n_results,
    output int                n_ok,
    output int                n_badsum,
    output int                n_timeout,
    output int                n_toolong
);

    localparam logic [7:0] HEADER_BYTE  = 8'hFF;
    localparam logic [7:0] ALT_SUM      = 8'hFE;
    localparam logic [2:0] TIMEOUT_ADDR = {cfr_pkg::REG_TIMEOUT, 2'b00};
    localparam int         FB_IDX_W     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    typedef enum logic [1:0] {HUNT, LENGTH, PAYLOAD, CHECKSUM} parse_phase_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [3:0][8:0] stick;
        logic [3:0]      sw_main;
        logic [3:0][1:0] sw;
    } ctrl_result_t;

    parse_phase_t phase;
    logic [7:0]   frame_len;
    logic [7:0]   byte_cnt;
    logic [7:0]   xor_acc;
    logic [15:0]  ticks;
    logic [15:0]  timeout_lim;
    logic [7:0]   frame_bytes [MAX_PAYLOAD];
    logic [7:0]   held [cfr_pkg::HELD_DEPTH];
    ctrl_result_t due_results [$];
    ctrl_result_t want;
    ctrl_result_t got;
    int           k;

    function automatic ctrl_result_t decode_held(input logic [1:0] st);
        ctrl_result_t r;
        int j;
        r.status = st;
        for (j = 0; j < 4; j++)
            r.stick[j] = held[0][j] ? 9'd0 - {1'b0, held[j+1]} : {1'b0, held[j+1]};
        r.sw_main = held[0][7:4];
        for (j = 0; j < 4; j++)
            r.sw[j] = held[5][2*j +: 2];
        return r;
    endfunction

    task automatic back_to_hunt();
        phase    = HUNT;
        byte_cnt = '0;
        xor_acc  = '0;
        ticks    = '0;
    endtask

    task automatic advance_parser(input logic req, input logic [7:0] b);
        logic ok;
        int   i;
        if (req == cfr_pkg::REQ_TICK) begin
            if (phase != HUNT) begin
                if (ticks != 16'hFFFF)
                    ticks = ticks + 16'd1;
                if (ticks > timeout_lim) begin
                    back_to_hunt();
                    due_results.push_back(decode_held(cfr_pkg::ST_TIMEOUT));
                end
            end
        end else begin
            case (phase)
                HUNT: begin
                    if (b == HEADER_BYTE) begin
                        phase = LENGTH;
                        ticks = '0;
                    end
                end
                LENGTH: begin
                    frame_len = b;
                    byte_cnt  = '0;
                    xor_acc   = '0;
                    if (int'(b) > MAX_PAYLOAD) begin
                        back_to_hunt();
                        due_results.push_back(decode_held(cfr_pkg::ST_TOOLONG));
                    end else begin
                        phase = (b == 8'd0) ? CHECKSUM : PAYLOAD;
                    end
                end
                PAYLOAD: begin
                    if (int'(byte_cnt) < MAX_PAYLOAD)
                        frame_bytes[byte_cnt[FB_IDX_W-1:0]] = b;
                    xor_acc  = xor_acc ^ b;
                    byte_cnt = byte_cnt + 8'd1;
                    if (byte_cnt >= frame_len)
                        phase = CHECKSUM;
                end
                default: begin
                    ok = (b == xor_acc) || (xor_acc == HEADER_BYTE && b == ALT_SUM);
                    // only bytes of this frame are copied, so nothing stale is read
                    if (ok) begin
                        for (i = 0; i < cfr_pkg::HELD_DEPTH; i++)
                            if (i < int'(frame_len) && i < MAX_PAYLOAD)
                                held[i] = frame_bytes[i];
                    end
                    back_to_hunt();
                    due_results.push_back(decode_held(ok ? cfr_pkg::ST_OK
                                                         : cfr_pkg::ST_BADSUM));
                end
            endcase
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch in %s (result %0d): expected 0x%0h, got 0x%0h",
                         what, n_results, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            timeout_lim = cfr_pkg::TIMEOUT_RESET;
            frame_len   = '0;
            for (k = 0; k < cfr_pkg::HELD_DEPTH; k++)
                held[k] = '0;
            back_to_hunt();
            due_results.delete();
            fail_count = 0;
            n_results  = 0;
            n_ok       = 0;
            n_badsum   = 0;
            n_timeout  = 0;
            n_toolong  = 0;
            pending   <= 0;
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr == TIMEOUT_ADDR)
                        timeout_lim = pwdata[15:0];
                end else if (paddr == TIMEOUT_ADDR) begin
                    check_field("timeout_ticks readback", {16'd0, timeout_lim}, prdata);
                end
            end

            if (m_valid && m_ready) begin
                n_results++;
                case (m_status)
                    cfr_pkg::ST_OK:      n_ok++;
                    cfr_pkg::ST_BADSUM:  n_badsum++;
                    cfr_pkg::ST_TIMEOUT: n_timeout++;
                    default:             n_toolong++;
                endcase
                if (due_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result %0d with status %0d arrived with nothing due",
                                 n_results, m_status);
                end else begin
                    want        = due_results.pop_front();
                    got.status  = m_status;
                    got.stick   = {m_stick_3, m_stick_2, m_stick_1, m_stick_0};
                    got.sw_main = m_switch_main;
                    got.sw      = {m_switch_4, m_switch_3, m_switch_2, m_switch_1};
                    check_field("status", 32'(want.status), 32'(got.status));
                    for (k = 0; k < 4; k++)
                        check_field($sformatf("stick_%0d", k), 32'(want.stick[k]),
                                    32'(got.stick[k]));
                    check_field("switch_main", 32'(want.sw_main), 32'(got.sw_main));
                    for (k = 0; k < 4; k++)
                        check_field($sformatf("switch_%0d", k + 1), 32'(want.sw[k]),
                                    32'(got.sw[k]));
                end
            end

            if (s_valid && s_ready)
                advance_parser(s_req_type, s_rx_byte);

            pending <= due_results.size();
        end
    end

endmodule

// ===== verif/controller_frame_receiver_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top: drives bytes, ticks and register writes into the frame receiver.
module controller_frame_receiver_top_tb;

    localparam int         MAX_PAYLOAD    = 16;
    localparam logic [7:0] HEADER_BYTE    = 8'hFF;
    localparam logic [2:0] TIMEOUT_ADDR   = {cfr_pkg::REG_TIMEOUT, 2'b00};
    // one word above the only register: writes there must be dropped
    localparam logic [2:0] SPARE_ADDR     = {1'b1, 2'b00};
    // results pass through the event queue and output register; allow a generous margin
    localparam int         DRAIN_TAIL     = 8;
    localparam int         WATCHDOG_LIMIT = 2000;

    typedef enum {SUM_GOOD, SUM_ALT, SUM_LESS, SUM_BAD} sum_mode_t;

    logic              aclk;
    logic              aresetn    = 1'b0;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [2:0]        paddr      = '0;
    logic [31:0]       pwdata     = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_valid    = 1'b0;
    logic              s_ready;
    logic              s_req_type = 1'b0;
    logic [7:0]        s_rx_byte  = '0;
    logic              m_valid;
    logic              m_ready    = 1'b0;
    logic [1:0]        m_status;
    logic signed [8:0] m_stick_0;
    logic signed [8:0] m_stick_1;
    logic signed [8:0] m_stick_2;
    logic signed [8:0] m_stick_3;
    logic [3:0]        m_switch_main;
    logic [1:0]        m_switch_1;
    logic [1:0]        m_switch_2;
    logic [1:0]        m_switch_3;
    logic [1:0]        m_switch_4;

    int fail_count;
    int pending;
    int n_results;
    int n_ok;
    int n_badsum;
    int n_timeout;
    int n_toolong;

    // stimulus state
    logic       steady      = 1'b0;  // suppress idling on both sides
    logic       noise       = 1'b0;  // items sent now do not count towards the total
    int         tick_pct    = 0;     // chance of a tick burst ahead of each frame byte after the header
    int         timeout_now = 100;
    int         item_count  = 0;
    int         quiet       = 0;
    logic [7:0] frame_q [$];

    controller_frame_receiver_top #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_stick_0     (m_stick_0),
        .m_stick_1     (m_stick_1),
        .m_stick_2     (m_stick_2),
        .m_stick_3     (m_stick_3),
        .m_switch_main (m_switch_main),
        .m_switch_1    (m_switch_1),
        .m_switch_2    (m_switch_2),
        .m_switch_3    (m_switch_3),
        .m_switch_4    (m_switch_4)
    );

    cfr_frame_monitor #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_monitor (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_stick_0     (m_stick_0),
        .m_stick_1     (m_stick_1),
        .m_stick_2     (m_stick_2),
        .m_stick_3     (m_stick_3),
        .m_switch_main (m_switch_main),
        .m_switch_1    (m_switch_1),
        .m_switch_2    (m_switch_2),
        .m_switch_3    (m_switch_3),
        .m_switch_4    (m_switch_4),
        .fail_count    (fail_count),
        .pending       (pending),
        .n_results     (n_results),
        .n_ok          (n_ok),
        .n_badsum      (n_badsum),
        .n_timeout     (n_timeout),
        .n_toolong     (n_toolong)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Result side: stall at random, about 7 percent of the time, never while steady.
    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 7);
    end

    // Watchdog: count cycles without any transfer and give up past the limit.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results still due",
                     quiet, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one item and hold it until the transfer. Called and returns at a falling
    // edge; valid is left high so that a following item can go out without a gap.
    task automatic send_item(input logic req, input logic [7:0] b);
        while (!steady && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_rx_byte  <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (!noise)
            item_count++;
    endtask

    // Send a byte that belongs to a frame, sometimes preceded by a short tick burst.
    task automatic frame_byte(input logic [7:0] b);
        if ($urandom_range(99) < tick_pct)
            repeat ($urandom_range(1, 3)) send_item(cfr_pkg::REQ_TICK, 8'($urandom));
        send_item(cfr_pkg::REQ_BYTE, b);
    endtask

    // Send header, length, the payload held in frame_q and a checksum of the given kind.
    task automatic send_frame(input sum_mode_t mode);
        logic [7:0] acc;
        int         i;
        acc = '0;
        send_item(cfr_pkg::REQ_BYTE, HEADER_BYTE);
        frame_byte(8'(frame_q.size()));
        for (i = 0; i < frame_q.size(); i++) begin
            frame_byte(frame_q[i]);
            acc = acc ^ frame_q[i];
        end
        case (mode)
            SUM_GOOD: frame_byte(acc);
            SUM_ALT:  frame_byte(8'hFE);        // only good when the XOR is all ones
            SUM_LESS: frame_byte(acc - 8'd1);   // must be rejected unless XOR is all ones
            default:  frame_byte(acc ^ 8'($urandom_range(1, 255)));
        endcase
    endtask

    // Build a well-formed frame with random content; mostly short, sometimes full size.
    task automatic random_frame();
        int         len;
        int         pick;
        int         i;
        logic [7:0] acc;
        sum_mode_t  mode;
        pick = $urandom_range(99);
        if (pick < 70)
            len = $urandom_range(0, 6);
        else if (pick < 95)
            len = $urandom_range(7, MAX_PAYLOAD - 1);
        else
            len = MAX_PAYLOAD;
        frame_q.delete();
        acc = '0;
        for (i = 0; i < len; i++) begin
            pick = $urandom_range(9);
            if (pick == 0)
                frame_q.push_back(HEADER_BYTE);
            else if (pick == 1)
                frame_q.push_back(8'h00);
            else
                frame_q.push_back(8'($urandom));
            acc = acc ^ frame_q[i];
        end
        // force an all-ones XOR now and then to reach the alternative checksum
        if (len > 0 && $urandom_range(99) < 15) begin
            frame_q[len-1] = frame_q[len-1] ^ acc ^ HEADER_BYTE;
            acc = HEADER_BYTE;
        end
        pick = $urandom_range(99);
        if (acc == HEADER_BYTE)
            mode = (pick < 50) ? SUM_ALT : (pick < 90) ? SUM_GOOD : SUM_BAD;
        else if (pick < 72)
            mode = SUM_GOOD;
        else if (pick < 80)
            mode = SUM_LESS;
        else if (pick < 85)
            mode = SUM_ALT;
        else
            mode = SUM_BAD;
        send_frame(mode);
    endtask

    // Start a frame and cut it short; run the timer out when the limit is within reach.
    task automatic broken_frame();
        int len;
        int cut;
        int i;
        len = $urandom_range(1, MAX_PAYLOAD);
        cut = $urandom_range(0, len - 1);
        send_item(cfr_pkg::REQ_BYTE, HEADER_BYTE);
        frame_byte(8'(len));
        for (i = 0; i < cut; i++)
            frame_byte(8'($urandom));
        if (timeout_now <= 200)
            repeat (timeout_now + 1) send_item(cfr_pkg::REQ_TICK, 8'($urandom));
    endtask

    // Bytes and ticks between frames, which a hunting receiver drops.
    task automatic line_noise();
        int i;
        noise = 1'b1;
        for (i = 0; i < $urandom_range(1, 4); i++) begin
            if ($urandom_range(1) == 1)
                send_item(cfr_pkg::REQ_TICK, 8'($urandom));
            else
                send_item(cfr_pkg::REQ_BYTE, 8'($urandom_range(0, 254)));
        end
        noise = 1'b0;
    endtask

    task automatic random_traffic(input int n_items);
        int first;
        int pick;
        first    = item_count;
        tick_pct = 8;
        while (item_count - first < n_items) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
                random_frame();
            end else if (pick < 80) begin
                send_item(cfr_pkg::REQ_BYTE, HEADER_BYTE);
                frame_byte(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
            end else if (pick < 90) begin
                line_noise();
            end else begin
                broken_frame();
            end
        end
    endtask

    // Drop valid, wait for every due result, then let the pipeline settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (DRAIN_TAIL) @(negedge aclk);
    endtask

    // One register access: setup cycle, access cycle, then an idle cycle.
    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_timeout(input int limit);
        drain();
        apb_access(1'b1, TIMEOUT_ADDR, 32'(limit));
        apb_access(1'b0, TIMEOUT_ADDR, '0);
        timeout_now = limit;
    endtask

    initial begin
        // hold reset, then release it at a falling edge
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // the register must read back its reset value
        apb_access(1'b0, TIMEOUT_ADDR, '0);

        // --- directed part, timeout at its reset value ---
        // tick while hunting: no result
        send_item(cfr_pkg::REQ_TICK, 8'h00);
        // zero length: checksum compared against zero
        frame_q = {};
        send_frame(SUM_GOOD);
        // all-ones XOR accepted with the alternative checksum; sign bits and top switches set
        frame_q = {8'hF5, 8'hFF, 8'h80, 8'h01, 8'h00, 8'h74};
        send_frame(SUM_ALT);
        // length one above the limit, and the largest length
        send_item(cfr_pkg::REQ_BYTE, HEADER_BYTE);
        send_item(cfr_pkg::REQ_BYTE, 8'(MAX_PAYLOAD + 1));
        send_item(cfr_pkg::REQ_BYTE, HEADER_BYTE);
        send_item(cfr_pkg::REQ_BYTE, 8'hFF);
        // header value inside a frame is plain payload
        frame_q = {8'hFF, 8'hFF};
        send_frame(SUM_GOOD);
        // checksum one below the XOR must be rejected
        frame_q = {8'h12};
        send_frame(SUM_LESS);

        // --- shortest timeout: the second tick after a header fires it ---
        set_timeout(1);
        send_item(cfr_pkg::REQ_BYTE, HEADER_BYTE);
        send_item(cfr_pkg::REQ_TICK, 8'hFF);
        send_item(cfr_pkg::REQ_TICK, 8'h00);
        random_traffic(300);

        // a write to an unmapped word must leave the timeout alone
        set_timeout(3);
        apb_access(1'b1, SPARE_ADDR, 32'($urandom));
        apb_access(1'b0, TIMEOUT_ADDR, '0);
        random_traffic(300);

        // medium timeout; hold off mid-way until the receiver has caught up,
        // then run a long stretch with neither side idling
        set_timeout(40);
        random_traffic(150);
        drain();
        steady = 1'b1;
        random_traffic(250);
        steady = 1'b0;

        // largest timeout: a long run of ticks never ends the frame
        set_timeout(65535);
        send_item(cfr_pkg::REQ_BYTE, HEADER_BYTE);
        send_item(cfr_pkg::REQ_BYTE, 8'd1);
        repeat (120) send_item(cfr_pkg::REQ_TICK, 8'($urandom));
        send_item(cfr_pkg::REQ_BYTE, 8'h5A);
        send_item(cfr_pkg::REQ_BYTE, 8'h5A);
        random_traffic(300);

        set_timeout($urandom_range(1, 200));
        random_traffic(200);

        drain();
        repeat (20) @(negedge aclk);

        $display("Covered %0d counted input transfers and %0d results with timeouts 1..65535.",
                 item_count, n_results);
        $display("Results: %0d accepted, %0d bad checksum, %0d timed out, %0d too long.",
                 n_ok, n_badsum, n_timeout, n_toolong);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches in total", fail_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/cfr_pkg.sv
hdl/cfr_front.sv
hdl/cfr_queue.sv
hdl/cfr_back.sv
hdl/controller_frame_receiver_top.sv
verif/cfr_frame_monitor.sv
verif/controller_frame_receiver_top_tb.sv
